// ===== sv/pict_pkg.sv =====
// ----------------------------------------------------------------------------
// pict_pkg: shared types and constants for the PWM input capture timer
// Register indexes, reset values and the filter edge struct.
// ----------------------------------------------------------------------------
package pict_pkg;

	localparam int CountW  = 16;
	localparam int FiltW   = 4;
	localparam int CfgIdxW = 2;
	localparam int CfgW    = 16;

	typedef enum logic [CfgIdxW-1:0] {
		REG_PRESCALE = 2'd0,
		REG_TOP      = 2'd1,
		REG_FILTER   = 2'd2
	} reg_index_t;

	localparam logic [CountW-1:0] PrescaleReset = 16'd7;
	localparam logic [CountW-1:0] TopReset      = 16'hFFFF;
	localparam logic [FiltW-1:0]  FilterReset   = 4'd8;
	localparam logic [FiltW-1:0]  RunMax        = 4'd15;

	typedef struct packed {
		logic rising;
		logic falling;
	} edge_t;

endpackage

// ===== sv/pwm_input_capture_timer.sv =====
// ----------------------------------------------------------------------------
// pwm_input_capture_timer: PWM input capture, reset mode
// Filter, prescaler, counter and period/width capture with a sticky lost flag.
// ----------------------------------------------------------------------------
// Results are registered in the output register, or in the skid entry on a stall.
// Throughput: one transaction per cycle while the skid entry is empty; the filter, prescaler
// and counter update in the cycle of acceptance, a two-entry output buffer absorbs a stall.
// Reset: asynchronous, state zero but for the output data, registers at their default values.
module pwm_input_capture_timer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // pin_level, clear_lost
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [39:0]                   m_axis_tdata,  // pulse_width, period_count, signal_lost
	input  logic                          cfg_we,
	input  logic [pict_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [pict_pkg::CfgW-1:0]     cfg_wdata
);

	localparam int ResW = 2 * pict_pkg::CountW + 1;

	logic [pict_pkg::CountW-1:0] divider_q;
	logic [pict_pkg::CountW-1:0] top_q;
	logic [pict_pkg::FiltW-1:0]  filt_len_q;

	logic [pict_pkg::CountW-1:0] presc_q;
	logic [pict_pkg::CountW-1:0] count_q;
	logic [pict_pkg::CountW-1:0] period_q;
	logic [pict_pkg::CountW-1:0] width_q;
	logic                        lost_q;

	logic                        accept;
	logic                        pin;
	logic                        clr;
	pict_pkg::edge_t             edges;
	logic                        presc_exp;
	logic                        wrap;
	logic [pict_pkg::CountW-1:0] presc_d;
	logic [pict_pkg::CountW-1:0] count_d;
	logic [pict_pkg::CountW-1:0] period_d;
	logic [pict_pkg::CountW-1:0] width_d;
	logic                        lost_d;
	logic [ResW-1:0]             result;

	logic            out_v_q;
	logic [ResW-1:0] out_q;
	logic            skid_v_q;
	logic [ResW-1:0] skid_q;

	assign s_axis_tready = !skid_v_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign pin           = s_axis_tdata[0];
	assign clr           = s_axis_tdata[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q  <= pict_pkg::PrescaleReset;
			top_q      <= pict_pkg::TopReset;
			filt_len_q <= pict_pkg::FilterReset;
		end else if (cfg_we) begin
			case (cfg_index)
				pict_pkg::REG_PRESCALE: divider_q  <= cfg_wdata;
				pict_pkg::REG_TOP:      top_q      <= cfg_wdata;
				pict_pkg::REG_FILTER:   filt_len_q <= cfg_wdata[pict_pkg::FiltW-1:0];
				default: ;
			endcase
		end
	end

	pict_filter u_filter (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (accept),
		.pin           (pin),
		.filter_length (filt_len_q),
		.edges         (edges)
	);

	assign presc_exp = presc_q >= divider_q;
	assign wrap      = !edges.rising && presc_exp && (count_q >= top_q);

	always_comb begin
		presc_d  = presc_q;
		count_d  = count_q;
		period_d = period_q;
		width_d  = width_q;
		if (edges.rising) begin
			period_d = count_q;
			count_d  = '0;
			presc_d  = '0;
		end else begin
			if (edges.falling) width_d = count_q;
			if (presc_exp) begin
				presc_d = '0;
				count_d = wrap ? '0 : count_q + pict_pkg::CountW'(1);
			end else begin
				presc_d = presc_q + pict_pkg::CountW'(1);
			end
		end
		lost_d = lost_q || wrap;
	end

	assign result = {lost_d, period_d, width_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q  <= '0;
			count_q  <= '0;
			period_q <= '0;
			width_q  <= '0;
			lost_q   <= 1'b0;
		end else if (accept) begin
			presc_q  <= presc_d;
			count_q  <= count_d;
			period_q <= period_d;
			width_q  <= width_d;
			// clear takes effect after this transaction's report
			lost_q   <= lost_d && !clr;
		end
	end

	// output register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			if (skid_v_q) out_q <= skid_q;
			else if (accept) out_q <= result;
		end else if (accept) begin
			skid_q <= result;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {{(40 - ResW){1'b0}}, out_q};

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid with empty output register");

	a_period_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !edges.rising) |=> $stable(period_q))
		else $error("period capture changed without a rising edge");

	a_wrap_sets_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && wrap && !clr) |=> lost_q)
		else $error("counter wrap did not set the lost flag");
`endif

endmodule

// ===== sv/pict_filter.sv =====
// ----------------------------------------------------------------------------
// pict_filter: digital input filter
// Filtered level changes after filter_length consecutive differing samples.
// ----------------------------------------------------------------------------
module pict_filter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      pin,
	input  logic [pict_pkg::FiltW-1:0] filter_length,
	output pict_pkg::edge_t           edges
);

	logic                       level_q;
	logic [pict_pkg::FiltW-1:0] run_q;
	logic [pict_pkg::FiltW-1:0] need;
	logic [pict_pkg::FiltW-1:0] run_inc;
	logic                       differ;
	logic                       change;

	// zero length behaves as one
	assign need    = (filter_length == '0) ? pict_pkg::FiltW'(1) : filter_length;
	assign differ  = pin != level_q;
	assign run_inc = (run_q < pict_pkg::RunMax) ? run_q + pict_pkg::FiltW'(1) : run_q;
	assign change  = differ && (run_inc >= need);

	assign edges.rising  = change && pin;
	assign edges.falling = change && !pin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			run_q   <= '0;
		end else if (en) begin
			if (change) begin
				level_q <= pin;
				run_q   <= '0;
			end else if (differ) begin
				run_q <= run_inc;
			end else begin
				run_q <= '0;
			end
		end
	end

endmodule
